[sv/afrf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afrf_pkg
// Shared types and constants for the aligned fill run finder.
// ----------------------------------------------------------------------------
package afrf_pkg;

  // Default parameter values
  localparam int unsigned OFFSET_BITS_DEF = 25;
  localparam logic [31:0] ROM_BASE_DEF    = 32'h0800_0000;

  // Fixed field widths
  localparam int unsigned MIN_SIZE_W  = 26;
  localparam int unsigned ADDR_W      = 28;
  localparam int unsigned CFG_IDX_W   = 8;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned NUM_TRACK   = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SIZE        = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LARGEST_MODE    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRIMARY_FILLER  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FALLBACK_FILLER = 8'd3;

  // Register reset values
  localparam logic [MIN_SIZE_W-1:0] MIN_SIZE_RST        = 26'd1;
  localparam logic [7:0]            PRIMARY_FILLER_RST  = 8'hFF;
  localparam logic [7:0]            FALLBACK_FILLER_RST = 8'h00;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] space_address;
    logic              used_fallback;
  } out_t;

endpackage

[sv/aligned_fill_run_finder_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aligned_fill_run_finder_core
// Scans an image byte stream for runs of filler bytes that start on 4-byte
// boundaries and reports the chosen free space address at the last byte.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries one image
//   byte per transaction, in address order; last_byte marks the end.
//   Output channel (out_valid_o / out_stall_i / out_data_o) carries one
//   result transaction per image, loaded on the cycle after the last byte.
//   Configuration channel (cfg_valid_i / cfg_ready_o) writes min_size,
//   largest_mode, primary_filler and fallback_filler; it is always ready.
//   Indexes beyond the register list are dropped.
// Throughput: one byte per cycle while the input is not stalled. Both filler
//   trackers compare, count and update their kept run combinationally from
//   the stored scan state; the result register sits behind that logic.
// Latency: result valid on the cycle after the last byte is accepted.
// Stall: the result register holds while out_stall_i is high; the input is
//   stalled only while that register is full and stalled, so a new image
//   streams in as soon as the result leaves.
// Reset: registers return to their documented defaults and the scan starts
//   at offset 0. After each last byte the scan state clears on its own.
// ----------------------------------------------------------------------------
module aligned_fill_run_finder_core
  import afrf_pkg::*;
#(
  parameter int unsigned OFFSET_BITS = OFFSET_BITS_DEF,
  parameter logic [31:0] ROM_BASE    = ROM_BASE_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // byte input
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  afrf_pkg::in_t                      in_data_i,
  // result output
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output afrf_pkg::out_t                     out_data_o,
  // configuration writes
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [afrf_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [afrf_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int unsigned LenW = OFFSET_BITS + 1;
  localparam int unsigned CmpW = (LenW > MIN_SIZE_W) ? LenW : MIN_SIZE_W;

  // Configuration registers
  logic [MIN_SIZE_W-1:0] min_size_q;
  logic                  largest_mode_q;
  logic [7:0]            primary_filler_q;
  logic [7:0]            fallback_filler_q;

  // Scan state
  logic [OFFSET_BITS-1:0] byte_offset_q, byte_offset_d;
  logic [NUM_TRACK-1:0]   run_active_q, run_active_d;
  logic [OFFSET_BITS-1:0] run_start_q   [NUM_TRACK];
  logic [OFFSET_BITS-1:0] run_start_d   [NUM_TRACK];
  logic [LenW-1:0]        run_len_q     [NUM_TRACK];
  logic [LenW-1:0]        run_len_d     [NUM_TRACK];
  logic [OFFSET_BITS-1:0] best_start_q  [NUM_TRACK];
  logic [OFFSET_BITS-1:0] best_start_d  [NUM_TRACK];
  logic [LenW-1:0]        best_len_q    [NUM_TRACK];
  logic [LenW-1:0]        best_len_d    [NUM_TRACK];

  // Result register
  logic  out_valid_q, out_valid_d;
  out_t  out_data_q, out_data_d;

  logic in_acc;
  logic out_acc;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_acc      = in_valid_i & ~in_stall_o;
  assign out_acc     = out_valid_q & ~out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // --------------------------------------------------------------------------
  // Configuration decode
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_size_q        <= MIN_SIZE_RST;
      largest_mode_q    <= 1'b0;
      primary_filler_q  <= PRIMARY_FILLER_RST;
      fallback_filler_q <= FALLBACK_FILLER_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_MIN_SIZE:        min_size_q        <= cfg_data_i[MIN_SIZE_W-1:0];
        CFG_LARGEST_MODE:    largest_mode_q    <= cfg_data_i[0];
        CFG_PRIMARY_FILLER:  primary_filler_q  <= cfg_data_i[7:0];
        CFG_FALLBACK_FILLER: fallback_filler_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Tracker update: one compare, one saturating count and one keep decision
  // per filler, all from the stored state.
  // --------------------------------------------------------------------------
  logic [7:0]             filler      [NUM_TRACK];
  logic                   match       [NUM_TRACK];
  logic                   act_n       [NUM_TRACK];
  logic [OFFSET_BITS-1:0] start_n     [NUM_TRACK];
  logic [LenW-1:0]        len_n       [NUM_TRACK];
  logic                   close_en    [NUM_TRACK];
  logic [LenW-1:0]        close_len   [NUM_TRACK];
  logic                   locked      [NUM_TRACK];
  logic                   keep        [NUM_TRACK];
  logic [OFFSET_BITS-1:0] best_start_n[NUM_TRACK];
  logic [LenW-1:0]        best_len_n  [NUM_TRACK];
  logic                   aligned;
  logic                   last;
  logic                   pick_fb;
  logic                   any_found;
  logic [31:0]            addr_sum;

  assign filler[0] = primary_filler_q;
  assign filler[1] = fallback_filler_q;
  assign aligned   = (byte_offset_q[1:0] == 2'b00);
  assign last      = in_data_i.last_byte;

  always_comb begin
    for (int t = 0; t < NUM_TRACK; t++) begin
      match[t]     = (in_data_i.data_byte == filler[t]);
      act_n[t]     = run_active_q[t];
      start_n[t]   = run_start_q[t];
      len_n[t]     = run_len_q[t];
      close_en[t]  = 1'b0;
      close_len[t] = run_len_q[t];
      if (run_active_q[t]) begin
        if (match[t]) begin
          // grow the run, saturate at all ones
          if (run_len_q[t] != {LenW{1'b1}}) begin
            len_n[t] = run_len_q[t] + LenW'(1);
          end
        end else begin
          close_en[t] = 1'b1;
          act_n[t]    = 1'b0;
        end
      end else if (match[t] && aligned) begin
        act_n[t]   = 1'b1;
        start_n[t] = byte_offset_q;
        len_n[t]   = LenW'(1);
      end
      // a run still open at the last byte ends there, with that byte counted
      if (last && act_n[t]) begin
        close_en[t]  = 1'b1;
        close_len[t] = len_n[t];
      end
      locked[t] = ~largest_mode_q && (best_len_q[t] != '0);
      keep[t]   = close_en[t] && ~locked[t]
                  && (CmpW'(close_len[t]) >= CmpW'(min_size_q))
                  && (close_len[t] > best_len_q[t]);
      best_start_n[t] = keep[t] ? start_n[t]   : best_start_q[t];
      best_len_n[t]   = keep[t] ? close_len[t] : best_len_q[t];
    end
  end

  // Pick primary when it kept a run, else fallback
  assign pick_fb   = (best_len_n[0] == '0);
  assign any_found = ~pick_fb || (best_len_n[1] != '0);
  assign addr_sum  = ROM_BASE + 32'(pick_fb ? best_start_n[1] : best_start_n[0]);

  always_comb begin
    byte_offset_d = byte_offset_q;
    run_active_d  = run_active_q;
    for (int t = 0; t < NUM_TRACK; t++) begin
      run_start_d[t]  = run_start_q[t];
      run_len_d[t]    = run_len_q[t];
      best_start_d[t] = best_start_q[t];
      best_len_d[t]   = best_len_q[t];
    end
    out_valid_d = out_valid_q & ~out_acc;
    out_data_d  = out_data_q;

    if (in_acc) begin
      if (last) begin
        // end of image: clear the scan and load the result
        byte_offset_d = '0;
        run_active_d  = '0;
        for (int t = 0; t < NUM_TRACK; t++) begin
          run_start_d[t]  = '0;
          run_len_d[t]    = '0;
          best_start_d[t] = '0;
          best_len_d[t]   = '0;
        end
        out_valid_d              = 1'b1;
        out_data_d.found         = any_found;
        out_data_d.space_address = any_found ? addr_sum[ADDR_W-1:0] : '0;
        out_data_d.used_fallback = any_found & pick_fb;
      end else begin
        byte_offset_d = byte_offset_q + OFFSET_BITS'(1);
        for (int t = 0; t < NUM_TRACK; t++) begin
          run_active_d[t] = act_n[t];
          run_start_d[t]  = start_n[t];
          run_len_d[t]    = len_n[t];
          best_start_d[t] = best_start_n[t];
          best_len_d[t]   = best_len_n[t];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_offset_q <= '0;
      run_active_q  <= '0;
      out_valid_q   <= 1'b0;
      for (int t = 0; t < NUM_TRACK; t++) begin
        run_start_q[t]  <= '0;
        run_len_q[t]    <= '0;
        best_start_q[t] <= '0;
        best_len_q[t]   <= '0;
      end
    end else begin
      byte_offset_q <= byte_offset_d;
      run_active_q  <= run_active_d;
      out_valid_q   <= out_valid_d;
      for (int t = 0; t < NUM_TRACK; t++) begin
        run_start_q[t]  <= run_start_d[t];
        run_len_q[t]    <= run_len_d[t];
        best_start_q[t] <= best_start_d[t];
        best_len_q[t]   <= best_len_d[t];
      end
    end
  end

  // Result payload needs no reset
  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_last_loads_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_data_i.last_byte) |=> out_valid_o)
    else $error("result not loaded after last byte");

  a_last_clears_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_data_i.last_byte) |=>
      (byte_offset_q == '0) && (run_active_q == '0))
    else $error("scan state not cleared after last byte");

  a_not_found_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.found) |->
      (out_data_o.space_address == '0) && !out_data_o.used_fallback)
    else $error("empty result carries address or fallback flag");

  a_active_len_p : assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_active_q[0] |-> (run_len_q[0] != '0))
    else $error("primary run active with zero length");

  a_active_len_f : assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_active_q[1] |-> (run_len_q[1] != '0))
    else $error("fallback run active with zero length");

endmodule

[tb/aligned_fill_run_finder_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aligned_fill_run_finder_core_tb
// Streams byte images into the free space finder under random idling and
// output holds, predicts each image's chosen run in a local scan model, and
// checks every result transaction field by field against that prediction.
// ----------------------------------------------------------------------------
module aligned_fill_run_finder_core_tb;
  import afrf_pkg::*;

  localparam int unsigned OFF_W          = OFFSET_BITS_DEF;
  localparam logic [OFF_W:0] RUN_LEN_MAX = '1;
  localparam logic [25:0] MIN_SIZE_HIGH  = 26'd33554432;
  localparam int unsigned RANDOM_ITEMS   = 1100;
  localparam int unsigned SEGMENT_ITEMS  = 140;
  localparam int unsigned IDLE_PCT       = 21;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned SETTLE_CYCLES  = 4;
  localparam int unsigned CYCLE_LIMIT    = 200000;

  typedef logic [7:0] byte_q_t[$];

  // Per-filler scan state of the local model
  typedef struct {
    logic             active;
    logic [OFF_W-1:0] start;
    logic [OFF_W:0]   len;
    logic [OFF_W-1:0] best_start;
    logic [OFF_W:0]   best_len;
  } fill_track_t;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_valid    = 1'b0;
  logic        in_stall;
  in_t         in_data     = '0;
  logic        out_valid;
  logic        out_stall   = 1'b0;
  out_t        out_data;
  logic        cfg_valid   = 1'b0;
  logic        cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // Model copy of the registers and the scan
  logic [25:0]      min_run;
  logic             keep_longest;
  logic [7:0]       fill_byte [NUM_TRACK];
  fill_track_t      fill_trk [NUM_TRACK];
  logic [OFF_W-1:0] scan_offset;

  out_t expected_spaces[$];

  int unsigned mismatches     = 0;
  int unsigned results_seen   = 0;
  int unsigned bytes_sent     = 0;
  int unsigned images_sent    = 0;
  int unsigned settings_seen  = 0;
  int unsigned cycle_count    = 0;
  bit          src_idle_en    = 1'b1;
  bit          sink_idle_en   = 1'b1;
  bit          hold_request   = 1'b0;
  int unsigned hold_left      = 0;

  aligned_fill_run_finder_core i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Scan model
  // --------------------------------------------------------------------------

  // Reset the scan to offset 0 with nothing kept
  function automatic void clear_scan_model();
    scan_offset = '0;
    for (int t = 0; t < NUM_TRACK; t++) begin
      fill_trk[t] = '{active: 1'b0, start: '0, len: '0, best_start: '0, best_len: '0};
    end
  endfunction

  // End the current run and keep it if it beats the kept one. In first mode
  // the earliest kept run is locked; ties never replace the kept run.
  function automatic void close_fill_run(int t);
    logic locked;
    locked = !keep_longest && (fill_trk[t].best_len != '0);
    if (!locked && fill_trk[t].len >= min_run && fill_trk[t].len > fill_trk[t].best_len) begin
      fill_trk[t].best_start = fill_trk[t].start;
      fill_trk[t].best_len   = fill_trk[t].len;
    end
    fill_trk[t].active = 1'b0;
  endfunction

  // Advance the model by one accepted byte; queue a result on the last byte
  function automatic void predict_scan_byte(in_t item);
    out_t        space;
    logic        hit;
    logic [31:0] addr_sum;
    int          pick;
    for (int t = 0; t < NUM_TRACK; t++) begin
      hit = (item.data_byte == fill_byte[t]);
      if (fill_trk[t].active) begin
        if (!hit) begin
          close_fill_run(t);
        end else if (fill_trk[t].len != RUN_LEN_MAX) begin
          fill_trk[t].len = fill_trk[t].len + 1'b1;
        end
      end else if (hit && scan_offset[1:0] == 2'b00) begin
        // Open a run only on a word boundary
        fill_trk[t].active = 1'b1;
        fill_trk[t].start  = scan_offset;
        fill_trk[t].len    = (OFF_W+1)'(1);
      end
      // A run still open at the last byte ends there
      if (item.last_byte && fill_trk[t].active) close_fill_run(t);
    end
    scan_offset = scan_offset + 1'b1;
    if (item.last_byte) begin
      pick = -1;
      if (fill_trk[0].best_len != '0) pick = 0;
      else if (fill_trk[1].best_len != '0) pick = 1;
      space = '0;
      if (pick >= 0) begin
        addr_sum            = ROM_BASE_DEF + 32'(fill_trk[pick].best_start);
        space.found         = 1'b1;
        space.space_address = addr_sum[ADDR_W-1:0];
        space.used_fallback = (pick == 1);
      end
      expected_spaces.push_back(space);
      clear_scan_model();
    end
  endfunction

  // --------------------------------------------------------------------------
  // Result checking: compare each accepted result with the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    out_t exp_space;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_spaces.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %p", $time, out_data);
        mismatches++;
      end else begin
        exp_space = expected_spaces.pop_front();
        if (out_data.found !== exp_space.found) begin
          $display("%0t: found mismatch: expected %0b, actual %0b",
                   $time, exp_space.found, out_data.found);
          mismatches++;
        end
        if (out_data.space_address !== exp_space.space_address) begin
          $display("%0t: space_address mismatch: expected 0x%07h, actual 0x%07h",
                   $time, exp_space.space_address, out_data.space_address);
          mismatches++;
        end
        if (out_data.used_fallback !== exp_space.used_fallback) begin
          $display("%0t: used_fallback mismatch: expected %0b, actual %0b",
                   $time, exp_space.used_fallback, out_data.used_fallback);
          mismatches++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output stall: random idling, or a long hold counted here on request
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_request) begin
      hold_request <= 1'b0;
      hold_left    <= HOLD_CYCLES;
      out_stall    <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= sink_idle_en && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding",
               $time, cycle_count, expected_spaces.size());
      $display("FAIL aligned_fill_run_finder_core");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Shared drivers
  // --------------------------------------------------------------------------

  // Offer one byte and wait for its transaction. Leave valid high afterwards
  // so that back-to-back bytes never lower and raise it in the same step.
  task automatic send_byte(input logic [7:0] value, input logic last);
    in_t item;
    item.data_byte = value;
    item.last_byte = last;
    while (src_idle_en && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    predict_scan_byte(item);
    bytes_sent++;
    if (last) images_sent++;
  endtask

  task automatic send_image(input byte_q_t img);
    foreach (img[k]) send_byte(img[k], k == img.size() - 1);
  endtask

  // Build an image mostly out of filler runs of random length and placement,
  // with random noise bytes between them
  task automatic send_random_image(input int unsigned usual_len, input int unsigned long_len);
    int unsigned img_len;
    int unsigned run_left;
    logic [7:0]  run_val;
    logic [7:0]  value;
    img_len  = ($urandom_range(9) == 0) ? $urandom_range(long_len, 1)
                                         : $urandom_range(usual_len, 1);
    run_left = 0;
    run_val  = '0;
    for (int unsigned k = 0; k < img_len; k++) begin
      if (run_left == 0 && $urandom_range(99) < 60) begin
        run_left = $urandom_range(12, 1);
        run_val  = $urandom_range(1) ? fill_byte[0] : fill_byte[1];
      end
      if (run_left != 0) begin
        value = run_val;
        run_left--;
      end else begin
        value = 8'($urandom());
      end
      send_byte(value, k == img_len - 1);
    end
  endtask

  // Wait for every predicted result, then let the block settle
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_spaces.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write one register; leave valid high so writes can follow back to back
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_MIN_SIZE:        min_run         = value[25:0];
      CFG_LARGEST_MODE:    keep_longest    = value[0];
      CFG_PRIMARY_FILLER:  fill_byte[0]    = value[7:0];
      CFG_FALLBACK_FILLER: fill_byte[1]    = value[7:0];
      default: ;
    endcase
  endtask

  // Write all four registers; pad unused upper bits with noise
  task automatic apply_settings(input logic [25:0] min_size, input logic longest,
                                input logic [7:0] primary, input logic [7:0] fallback);
    write_reg(CFG_MIN_SIZE,        {6'($urandom()), min_size});
    write_reg(CFG_LARGEST_MODE,    {31'($urandom()), longest});
    write_reg(CFG_PRIMARY_FILLER,  {24'($urandom()), primary});
    write_reg(CFG_FALLBACK_FILLER, {24'($urandom()), fallback});
    cfg_valid <= 1'b0;
    settings_seen++;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset values: first mode, min_size 1, primary 0xFF, fallback 0x00
  task automatic test_reset_defaults();
    // Skip the unaligned 0xFF at offset 1, keep the run at 4, resume at 8
    send_image('{8'h12, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h34, 8'hFF});
    // Single byte image: the fallback run opens and closes on the last byte
    send_image('{8'h00});
    drain_results();
  endtask

  // Longest mode with min_size 0: longer run replaces, equal run does not
  task automatic test_longest_and_ties();
    apply_settings(26'd0, 1'b1, 8'hFF, 8'h00);
    send_image('{8'hFF, 8'h11, 8'h22, 8'h33, 8'hFF, 8'hFF, 8'hFF, 8'h44,
                 8'hFF, 8'hFF, 8'hFF});
    drain_results();
  endtask

  // A large min_size (2^25): nothing qualifies. Also drop writes to unknown indexes.
  task automatic test_min_size_limit();
    apply_settings(MIN_SIZE_HIGH, 1'b0, 8'hFF, 8'h00);
    send_image('{8'hFF, 8'hFF, 8'h00, 8'h00});
    drain_results();
    write_reg(CFG_FALLBACK_FILLER + 1'b1, 32'h0000_0000);
    write_reg('1, 32'hFFFF_FFFF);
    cfg_valid <= 1'b0;
    send_image('{8'hFF});
    drain_results();
  endtask

  // Hold the output long enough that the block fills and stalls its input
  task automatic test_output_hold();
    apply_settings(26'($urandom_range(4, 1)), 1'($urandom()), 8'hFF, 8'h00);
    hold_request <= 1'b1;
    repeat (4) send_random_image(8, 16);
    drain_results();
  endtask

  // Random images over changing settings; one segment runs without idling
  task automatic test_random_images();
    int unsigned segment;
    int unsigned first_byte;
    int unsigned seg_end;
    logic [25:0] min_size;
    logic [7:0]  fill [2];
    segment    = 0;
    first_byte = bytes_sent;
    while (bytes_sent - first_byte < RANDOM_ITEMS) begin
      case ($urandom_range(5))
        0:       min_size = 26'd0;
        1:       min_size = 26'd1;
        2:       min_size = (segment % 3 == 0) ? MIN_SIZE_HIGH : 26'd1;
        default: min_size = 26'($urandom_range(12, 2));
      endcase
      for (int t = 0; t < 2; t++) begin
        case ($urandom_range(3))
          0:       fill[t] = 8'h00;
          1:       fill[t] = 8'hFF;
          default: fill[t] = 8'($urandom());
        endcase
      end
      // Now and then let both trackers hunt the same filler
      if ($urandom_range(7) == 0) fill[1] = fill[0];
      apply_settings(min_size, 1'($urandom()), fill[0], fill[1]);
      src_idle_en  = (segment != 2);
      sink_idle_en <= (segment != 2);
      seg_end = bytes_sent + SEGMENT_ITEMS;
      while (bytes_sent < seg_end) send_random_image(40, 200);
      drain_results();
      segment++;
    end
    src_idle_en  = 1'b1;
    sink_idle_en <= 1'b1;
  endtask

  initial begin
    min_run      = MIN_SIZE_RST;
    keep_longest = 1'b0;
    fill_byte[0] = PRIMARY_FILLER_RST;
    fill_byte[1] = FALLBACK_FILLER_RST;
    clear_scan_model();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_longest_and_ties();
    test_min_size_limit();
    test_output_hold();
    test_random_images();

    // Catch any late extra result
    repeat (SETTLE_CYCLES * 4) @(posedge clk);
    if (expected_spaces.size() != 0) begin
      $display("%0t: %0d predicted results never arrived", $time, expected_spaces.size());
      mismatches++;
    end
    $display("Streamed %0d bytes in %0d images under %0d register settings;",
             bytes_sent, images_sent, settings_seen);
    $display("checked %0d results, %0d mismatches.", results_seen, mismatches);
    if (mismatches == 0) begin
      $display("PASS aligned_fill_run_finder_core");
    end else begin
      $display("FAIL aligned_fill_run_finder_core");
    end
    $finish;
  end

endmodule
